// File: hw/rtl/tbpr_pkg.sv
// Package for the touch button press/release block: state and config types,
// source and event codes, register indexes. No dependencies.
`timescale 1ns / 1ps

package tbpr_pkg;

    typedef enum logic [1:0]
    {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_RELEASE = 2'd2
    } phase_t;

    localparam logic [1:0] SRC_A      = 2'd0;
    localparam logic [1:0] SRC_B      = 2'd1;
    localparam logic [1:0] SRC_CENTER = 2'd2;
    localparam logic [1:0] SRC_NONE   = 2'd3;

    localparam logic EV_PRESS   = 1'b0;
    localparam logic EV_RELEASE = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_TIME  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_A      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_B      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MASK_CENTER = 3'd4;

    localparam logic [15:0] PRESS_TIME_RST  = 16'd40;
    localparam logic [3:0]  DEBOUNCE_RST    = 4'd8;
    localparam logic [7:0]  MASK_A_RST      = 8'h02;
    localparam logic [7:0]  MASK_B_RST      = 8'h80;
    localparam logic [7:0]  MASK_CENTER_RST = 8'h08;

    typedef struct packed
    {
        logic [15:0] press_time;
        logic [3:0]  miss_limit;
        logic [7:0]  mask_a;
        logic [7:0]  mask_b;
        logic [7:0]  mask_center;
    } cfg_t;

    typedef struct packed
    {
        phase_t      phase;
        logic [1:0]  source;
        logic [15:0] timer;
        logic [3:0]  debounce_count;
    } state_t;

    typedef struct packed
    {
        logic       valid;
        logic       kind;
        logic [1:0] source;
    } event_t;

endpackage

// File: hw/rtl/tbpr_step.sv
// One poll of the press/release state machine: next state and event.
// Purely combinational; depends on tbpr_pkg.
`timescale 1ns / 1ps

module tbpr_step
(
    input  tbpr_pkg::cfg_t   cfg,
    input  tbpr_pkg::state_t state,
    input  logic [7:0]       sensor_status,
    input  logic             read_ok,
    input  logic [7:0]       elapsed_ms,
    output tbpr_pkg::state_t state_next,
    output tbpr_pkg::event_t ev
);

    logic [16:0] timer_sum;
    logic [15:0] timer_sat;
    logic [7:0]  cur_mask;
    logic        held;

    assign timer_sum = {1'b0, state.timer} + {9'd0, elapsed_ms};
    assign timer_sat = timer_sum[16] ? 16'hFFFF : timer_sum[15:0];

    always_comb
    begin
        case (state.source)
            tbpr_pkg::SRC_A:      cur_mask = cfg.mask_a;
            tbpr_pkg::SRC_B:      cur_mask = cfg.mask_b;
            tbpr_pkg::SRC_CENTER: cur_mask = cfg.mask_center;
            default:              cur_mask = 8'd0;
        endcase
    end

    assign held = (sensor_status & cur_mask) != 8'd0;

    always_comb
    begin
        state_next       = state;
        state_next.timer = timer_sat;
        ev.valid         = 1'b0;
        ev.kind          = tbpr_pkg::EV_PRESS;
        ev.source        = state.source;
        if (read_ok)
        begin
            case (state.phase)
                tbpr_pkg::PH_PRESS, tbpr_pkg::PH_RELEASE:
                begin
                    if (held)
                    begin
                        state_next.debounce_count = 4'd0;
                        if (state.phase == tbpr_pkg::PH_PRESS && timer_sat >= cfg.press_time)
                        begin
                            ev.valid         = 1'b1;
                            state_next.phase = tbpr_pkg::PH_RELEASE;
                        end
                    end
                    else if (state.debounce_count < cfg.miss_limit)
                    begin
                        state_next.debounce_count = state.debounce_count + 4'd1;
                    end
                    else
                    begin
                        // out of contact too long: glitch in press, release otherwise
                        state_next.source = tbpr_pkg::SRC_NONE;
                        state_next.phase  = tbpr_pkg::PH_IDLE;
                        if (state.phase == tbpr_pkg::PH_RELEASE)
                        begin
                            ev.valid = 1'b1;
                            ev.kind  = tbpr_pkg::EV_RELEASE;
                        end
                    end
                end
                default:
                begin
                    // idle: priority A, B, center
                    if ((sensor_status & cfg.mask_a) != 8'd0)
                        state_next.source = tbpr_pkg::SRC_A;
                    else if ((sensor_status & cfg.mask_b) != 8'd0)
                        state_next.source = tbpr_pkg::SRC_B;
                    else if ((sensor_status & cfg.mask_center) != 8'd0)
                        state_next.source = tbpr_pkg::SRC_CENTER;
                    if ((sensor_status & (cfg.mask_a | cfg.mask_b | cfg.mask_center)) != 8'd0)
                    begin
                        state_next.phase          = tbpr_pkg::PH_PRESS;
                        state_next.timer          = 16'd0;
                        state_next.debounce_count = 4'd0;
                    end
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/touch_button_press_release_fsm.sv
// Top level of the touch button press/release block: stream ports, input and
// result registers, config registers. Depends on tbpr_pkg and tbpr_step.
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata {elapsed_ms, sensor_status}, tuser read_ok
// m_*       out  m_tvalid/m_tready  tdata {6'b0, event_source}, tuser event_kind
// cfg_*     in   cfg_wr_en          cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; each poll waits
// in the input register, where the step logic runs, and lands in the result
// register. Polls that give no event leave the output idle.
// Reset (rst_n low) returns config to defaults and the machine to idle.
// A stalled output holds its word; the input keeps taking words until both
// the input and result registers are full.

module touch_button_press_release_fsm
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // sensor_status, elapsed_ms
    input  logic                                s_tuser,   // read_ok
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // event_source, zero pad
    output logic                                m_tuser,   // event_kind
    input  logic                                cfg_wr_en,
    input  logic [tbpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tbpr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tbpr_pkg::cfg_t   cfg_reg;
    tbpr_pkg::state_t state_reg;
    tbpr_pkg::state_t state_next;
    tbpr_pkg::event_t ev;

    logic        in_valid_reg;
    logic [7:0]  status_reg;
    logic        read_ok_reg;
    logic [7:0]  elapsed_reg;
    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [1:0]  out_source_reg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_time     <= tbpr_pkg::PRESS_TIME_RST;
            cfg_reg.miss_limit     <= tbpr_pkg::DEBOUNCE_RST;
            cfg_reg.mask_a         <= tbpr_pkg::MASK_A_RST;
            cfg_reg.mask_b         <= tbpr_pkg::MASK_B_RST;
            cfg_reg.mask_center    <= tbpr_pkg::MASK_CENTER_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tbpr_pkg::REG_PRESS_TIME:  cfg_reg.press_time     <= cfg_data;
                tbpr_pkg::REG_DEBOUNCE:    cfg_reg.miss_limit     <= cfg_data[3:0];
                tbpr_pkg::REG_MASK_A:      cfg_reg.mask_a         <= cfg_data[7:0];
                tbpr_pkg::REG_MASK_B:      cfg_reg.mask_b         <= cfg_data[7:0];
                tbpr_pkg::REG_MASK_CENTER: cfg_reg.mask_center    <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    tbpr_step u_step
    (
        .cfg           (cfg_reg),
        .state         (state_reg),
        .sensor_status (status_reg),
        .read_ok       (read_ok_reg),
        .elapsed_ms    (elapsed_reg),
        .state_next    (state_next),
        .ev            (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= tbpr_pkg::PH_IDLE;
            state_reg.source         <= tbpr_pkg::SRC_NONE;
            state_reg.timer          <= 16'd0;
            state_reg.debounce_count <= 4'd0;
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= ev.valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            status_reg  <= s_tdata[7:0];
            elapsed_reg <= s_tdata[15:8];
            read_ok_reg <= s_tuser;
        end
        if (advance && ev.valid)
        begin
            out_kind_reg   <= ev.kind;
            out_source_reg <= ev.source;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_source_reg};
    assign m_tuser  = out_kind_reg;

endmodule

// File: hw/rtl/tbpr_check.sv
// Port-level checks for the touch button press/release block, bound to the
// top level. Depends on touch_button_press_release_fsm.
`timescale 1ns / 1ps

module tbpr_check
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // a stalled output word stays
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    ap_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // only the A, B and center sources appear, pad bits zero
    ap_source: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[7:2] == 6'd0)
        else $error("bad event source");

    // input backpressure only when the result side is stalled
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

endmodule

bind touch_button_press_release_fsm tbpr_check u_tbpr_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
